@@ hw/rtl/brle_pkg.sv @@
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and types for the byte run-length encoder: widths,
// the queue between front and back, and the command and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

    // Largest chunk of literals or run bytes sent under one header
    localparam int MAX_CHUNK = 126;

    // Literal count and literal store index (chunk never exceeds 127)
    localparam int LIT_W = 7;
    // Literal store address: bank select on top of the index
    localparam int LIT_ADDR_W = LIT_W + 1;
    localparam int LIT_DEPTH = 2 ** LIT_ADDR_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Header flag of a literal span
    localparam logic [7:0] LIT_HDR = 8'h80;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int LANES = 4;

    // Pair count codes in a command
    localparam logic [1:0] PAIRS_NONE = 2'd0;
    localparam logic [1:0] PAIRS_ONE = 2'd1;
    localparam logic [1:0] PAIRS_TWO = 2'd2;

    // Everything one input item sends, in stream order:
    // literal span, up to two (length, value) pairs, terminating zero
    typedef struct packed {
        logic [LIT_W-1:0] lit_n;
        logic             lit_bank;
        logic [1:0]       pair_n;
        logic [7:0]       p0_len;
        logic [7:0]       p0_val;
        logic [7:0]       p1_len;
        logic [7:0]       p1_val;
        logic             eos;
    } cmd_t;

    // Literal store write from the front
    typedef struct packed {
        logic                  en;
        logic [LIT_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } lit_wr_t;

    // Back has read the last literal of a bank
    typedef struct packed {
        logic en;
        logic bank;
    } bank_rel_t;

endpackage

`default_nettype wire

@@ hw/rtl/byte_rle_encoder.sv @@
// Throughput: one input transfer per cycle. Input stalls while the 4-entry
//   command queue is full or the literal bank to be filled is still being read out.
// Reset: synchronous, active low; clears control state, no clearing pass.
// ----------------------------------------------------------------------------
// byte_rle_encoder
// Streaming run-length encoder for byte images: classifying front, command
// queue, and an emitter that packs up to four encoded bytes per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_rle_encoder #(
    parameter int MAX_CHUNK = brle_pkg::MAX_CHUNK
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [brle_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
    input  wire logic                            s_tuser,  // [0] req_type
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
    // [34:32] byte_count, [39:35] zero
    output logic [brle_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast   // last_item
);

    logic                q_in_valid, q_in_ready;
    brle_pkg::cmd_t      q_in_cmd;
    logic                q_out_valid, q_out_ready;
    brle_pkg::cmd_t      q_out_cmd;
    brle_pkg::lit_wr_t   lit_wr;
    brle_pkg::bank_rel_t rel;
    logic [31:0]         out_bytes;
    logic [2:0]          out_count;

    brle_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_eos   (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_cmd    (q_in_cmd),
        .lit_wr   (lit_wr),
        .rel      (rel)
    );

    brle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_cmd   (q_in_cmd),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_cmd   (q_out_cmd)
    );

    brle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_cmd     (q_out_cmd),
        .lit_wr    (lit_wr),
        .rel       (rel),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bytes (out_bytes),
        .out_count (out_count),
        .out_last  (m_tlast)
    );

    // Pack result fields, zero-filled to whole bytes
    assign m_tdata = {5'd0, out_count, out_bytes};

endmodule

`default_nettype wire

@@ hw/rtl/brle_queue.sv @@
// ----------------------------------------------------------------------------
// brle_queue
// Short command queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire brle_pkg::cmd_t wr_cmd,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output brle_pkg::cmd_t      rd_cmd
);

    brle_pkg::cmd_t                 slot_reg [brle_pkg::QUEUE_DEPTH];
    logic [brle_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [brle_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [brle_pkg::QPTR_W:0]      count_reg, count_next;
    logic                           push, pop;

    assign wr_ready = (count_reg != (brle_pkg::QPTR_W + 1)'(brle_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/brle_front.sv @@
// ----------------------------------------------------------------------------
// brle_front
// Classifier: tracks the look-ahead window, literal count and current run,
// writes literals to the store and issues one command per item that sends.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_front #(
    parameter int MAX_CHUNK = brle_pkg::MAX_CHUNK
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_eos,
    input  wire logic [7:0]          in_byte,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output brle_pkg::cmd_t           q_cmd,
    output brle_pkg::lit_wr_t        lit_wr,
    input  wire brle_pkg::bank_rel_t rel
);

    localparam int LW = brle_pkg::LIT_W;
    localparam logic [7:0] MAX_LEN = 8'(MAX_CHUNK);
    // Three equal bytes open a run; a very short chunk limit sends at once
    localparam logic START_EMIT = (3 >= MAX_CHUNK);
    localparam logic [LW-1:0] START_LEN = (3 >= MAX_CHUNK) ? LW'(3 - MAX_CHUNK) : LW'(3);

    logic          in_run_reg, in_run_next;
    logic [7:0]    run_val_reg, run_val_next;
    logic [LW-1:0] run_len_reg, run_len_next;
    logic [LW-1:0] lit_cnt_reg, lit_cnt_next;
    logic [7:0]    win0_reg, win0_next;
    logic [7:0]    win1_reg, win1_next;
    logic [1:0]    win_cnt_reg, win_cnt_next;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic          send;
    logic [7:0]    run_inc;
    logic [7:0]    lit_inc;
    brle_pkg::cmd_t cmd;

    // Stall while the bank being filled is still read by the back
    assign in_ready = q_ready && !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;
    assign q_valid  = accept && send;
    assign q_cmd    = cmd;
    assign run_inc  = {1'b0, run_len_reg} + 8'd1;
    assign lit_inc  = {1'b0, lit_cnt_reg} + 8'd1;

    // Classify the item and build its command
    always_comb begin
        in_run_next  = in_run_reg;
        run_val_next = run_val_reg;
        run_len_next = run_len_reg;
        lit_cnt_next = lit_cnt_reg;
        win0_next    = win0_reg;
        win1_next    = win1_reg;
        win_cnt_next = win_cnt_reg;
        bank_next    = bank_reg;
        send         = 1'b0;
        cmd          = '0;
        lit_wr       = '0;

        if (accept && !in_eos) begin
            if (in_run_reg) begin
                if (in_byte == run_val_reg) begin
                    // Extend the run; send a full chunk
                    if (run_inc >= MAX_LEN) begin
                        send         = 1'b1;
                        cmd.pair_n   = brle_pkg::PAIRS_ONE;
                        cmd.p0_len   = run_inc;
                        cmd.p0_val   = run_val_reg;
                        run_len_next = '0;
                    end else begin
                        run_len_next = run_inc[LW-1:0];
                    end
                end else begin
                    // Close the run and open the window
                    if (run_len_reg != '0) begin
                        send       = 1'b1;
                        cmd.pair_n = brle_pkg::PAIRS_ONE;
                        cmd.p0_len = {1'b0, run_len_reg};
                        cmd.p0_val = run_val_reg;
                    end
                    in_run_next  = 1'b0;
                    win0_next    = in_byte;
                    win_cnt_next = 2'd1;
                end
            end else if (win_cnt_reg == 2'd2) begin
                if ((win0_reg == win1_reg) && (win1_reg == in_byte)) begin
                    // Start a run after sending pending literals
                    if (lit_cnt_reg != '0) begin
                        send         = 1'b1;
                        cmd.lit_n    = lit_cnt_reg;
                        cmd.lit_bank = bank_reg;
                        bank_next    = !bank_reg;
                        lit_cnt_next = '0;
                    end
                    if (START_EMIT) begin
                        send       = 1'b1;
                        cmd.pair_n = brle_pkg::PAIRS_ONE;
                        cmd.p0_len = MAX_LEN;
                        cmd.p0_val = in_byte;
                    end
                    in_run_next  = 1'b1;
                    run_val_next = in_byte;
                    run_len_next = START_LEN;
                    win_cnt_next = 2'd0;
                end else begin
                    // Oldest window byte becomes a literal
                    lit_wr.en   = 1'b1;
                    lit_wr.addr = {bank_reg, lit_cnt_reg};
                    lit_wr.data = win0_reg;
                    if (lit_inc >= MAX_LEN) begin
                        send         = 1'b1;
                        cmd.lit_n    = lit_inc[LW-1:0];
                        cmd.lit_bank = bank_reg;
                        bank_next    = !bank_reg;
                        lit_cnt_next = '0;
                    end else begin
                        lit_cnt_next = lit_inc[LW-1:0];
                    end
                    win0_next = win1_reg;
                    win1_next = in_byte;
                end
            end else begin
                // Fill the window
                if (win_cnt_reg == 2'd0) begin
                    win0_next = in_byte;
                end else begin
                    win1_next = in_byte;
                end
                win_cnt_next = win_cnt_reg + 2'd1;
            end
        end else if (accept) begin
            // End of stream: flush everything, then the zero byte
            send    = 1'b1;
            cmd.eos = 1'b1;
            if (in_run_reg) begin
                if (run_len_reg != '0) begin
                    cmd.pair_n = brle_pkg::PAIRS_ONE;
                    cmd.p0_len = {1'b0, run_len_reg};
                    cmd.p0_val = run_val_reg;
                end
            end else begin
                if (lit_cnt_reg != '0) begin
                    cmd.lit_n    = lit_cnt_reg;
                    cmd.lit_bank = bank_reg;
                    bank_next    = !bank_reg;
                end
                if ((win_cnt_reg == 2'd2) && (win0_reg == win1_reg)) begin
                    cmd.pair_n = brle_pkg::PAIRS_ONE;
                    cmd.p0_len = 8'd2;
                    cmd.p0_val = win0_reg;
                end else if (win_cnt_reg == 2'd2) begin
                    cmd.pair_n = brle_pkg::PAIRS_TWO;
                    cmd.p0_len = 8'd1;
                    cmd.p0_val = win0_reg;
                    cmd.p1_len = 8'd1;
                    cmd.p1_val = win1_reg;
                end else if (win_cnt_reg == 2'd1) begin
                    cmd.pair_n = brle_pkg::PAIRS_ONE;
                    cmd.p0_len = 8'd1;
                    cmd.p0_val = win0_reg;
                end
            end
            in_run_next  = 1'b0;
            run_val_next = '0;
            run_len_next = '0;
            lit_cnt_next = '0;
            win_cnt_next = 2'd0;
        end
    end

    // Mark a bank busy when its span is queued, free it when read out
    always_comb begin
        busy_next = busy_reg;
        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (q_valid && (cmd.lit_n != '0)) begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg  <= 1'b0;
            run_len_reg <= '0;
            lit_cnt_reg <= '0;
            win_cnt_reg <= 2'd0;
            bank_reg    <= 1'b0;
            busy_reg    <= 2'b00;
        end else begin
            in_run_reg  <= in_run_next;
            run_len_reg <= run_len_next;
            lit_cnt_reg <= lit_cnt_next;
            win_cnt_reg <= win_cnt_next;
            bank_reg    <= bank_next;
            busy_reg    <= busy_next;
        end
    end

    // Hold window bytes and run value
    always_ff @(posedge aclk) begin
        run_val_reg <= run_val_next;
        win0_reg    <= win0_next;
        win1_reg    <= win1_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/brle_back.sv @@
// ----------------------------------------------------------------------------
// brle_back
// Emitter: walks each command one byte per unstalled cycle, reads from the
// banked literal store and packs bytes into four-lane result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire brle_pkg::cmd_t    q_cmd,
    input  wire brle_pkg::lit_wr_t lit_wr,
    output brle_pkg::bank_rel_t    rel,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            out_bytes,
    output logic [2:0]             out_count,
    output logic                   out_last
);

    localparam int LW = brle_pkg::LIT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_LIT  = 3'd2;
    localparam logic [2:0] ST_P0L  = 3'd3;
    localparam logic [2:0] ST_P0V  = 3'd4;
    localparam logic [2:0] ST_P1L  = 3'd5;
    localparam logic [2:0] ST_P1V  = 3'd6;
    localparam logic [2:0] ST_ZERO = 3'd7;

    // Step that follows the literal span (or opens a command without one)
    function automatic logic [2:0] after_lits(brle_pkg::cmd_t c);
        logic [2:0] st;
        if (c.pair_n != brle_pkg::PAIRS_NONE) begin
            st = ST_P0L;
        end else if (c.eos) begin
            st = ST_ZERO;
        end else begin
            st = ST_IDLE;
        end
        return st;
    endfunction

    logic [7:0]          mem [brle_pkg::LIT_DEPTH];
    logic [7:0]          rd_data_reg;

    logic [2:0]          state_reg, state_next;
    brle_pkg::cmd_t      cmd_reg, cmd_next;
    logic [LW-1:0]       idx_reg, idx_next;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_mem_reg, s1_mem_next;
    logic [7:0]          s1_val_reg, s1_val_next;
    logic                s1_end_reg, s1_end_next;
    logic                s1_last_reg, s1_last_next;

    logic [31:0]         acc_reg, acc_next;
    logic [1:0]          acc_cnt_reg, acc_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_bytes_reg, m_bytes_next;
    logic [2:0]          m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    logic                pop;
    logic                issue;
    logic                s1_take;
    logic                s1_done;
    logic                step_mem;
    logic [7:0]          step_val;
    logic [2:0]          step_after;
    logic                lit_end;
    logic [7:0]          s1_byte;
    logic [31:0]         acc_put;
    logic [brle_pkg::LIT_ADDR_W-1:0] rd_addr;

    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_valid && q_ready;
    assign out_valid = m_valid_reg;
    assign out_bytes = m_bytes_reg;
    assign out_count = m_count_reg;
    assign out_last  = m_last_reg;

    // Stage 1 drains into the packer unless a full or final group cannot leave
    assign s1_byte = s1_mem_reg ? rd_data_reg : s1_val_reg;
    assign s1_done = s1_end_reg || (acc_cnt_reg == 2'd3);
    assign s1_take = s1_valid_reg && (!s1_done || !m_valid_reg || out_ready);
    assign issue   = (state_reg != ST_IDLE) && (!s1_valid_reg || s1_take);
    assign lit_end = (idx_reg == LW'(cmd_reg.lit_n - 1'b1));
    assign rd_addr = {cmd_reg.lit_bank, idx_reg};

    assign rel.en   = issue && (state_reg == ST_LIT) && lit_end;
    assign rel.bank = cmd_reg.lit_bank;

    // Byte of the current step and the step after it
    always_comb begin
        step_mem   = 1'b0;
        step_val   = 8'd0;
        step_after = ST_IDLE;
        case (state_reg)
            ST_HDR: begin
                step_val   = brle_pkg::LIT_HDR | {1'b0, cmd_reg.lit_n};
                step_after = ST_LIT;
            end
            ST_LIT: begin
                step_mem   = 1'b1;
                step_after = lit_end ? after_lits(cmd_reg) : ST_LIT;
            end
            ST_P0L: begin
                step_val   = cmd_reg.p0_len;
                step_after = ST_P0V;
            end
            ST_P0V: begin
                step_val = cmd_reg.p0_val;
                if (cmd_reg.pair_n == brle_pkg::PAIRS_TWO) begin
                    step_after = ST_P1L;
                end else begin
                    step_after = cmd_reg.eos ? ST_ZERO : ST_IDLE;
                end
            end
            ST_P1L: begin
                step_val   = cmd_reg.p1_len;
                step_after = ST_P1V;
            end
            ST_P1V: begin
                step_val   = cmd_reg.p1_val;
                step_after = cmd_reg.eos ? ST_ZERO : ST_IDLE;
            end
            ST_ZERO: begin
                step_val   = 8'd0;
                step_after = ST_IDLE;
            end
            default: begin
                step_after = ST_IDLE;
            end
        endcase
    end

    // Sequence commands and feed stage 1
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        s1_valid_next = s1_valid_reg;
        s1_mem_next   = s1_mem_reg;
        s1_val_next   = s1_val_reg;
        s1_end_next   = s1_end_reg;
        s1_last_next  = s1_last_reg;

        if (pop) begin
            cmd_next   = q_cmd;
            idx_next   = '0;
            state_next = (q_cmd.lit_n != '0) ? ST_HDR : after_lits(q_cmd);
        end else if (issue) begin
            state_next = step_after;
            if (state_reg == ST_LIT) begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (issue) begin
            s1_valid_next = 1'b1;
            s1_mem_next   = step_mem;
            s1_val_next   = step_val;
            s1_end_next   = (step_after == ST_IDLE);
            s1_last_next  = (step_after == ST_IDLE) && cmd_reg.eos;
        end else if (s1_take) begin
            s1_valid_next = 1'b0;
        end
    end

    // Pack bytes into lanes; hand a full or final group to the output
    always_comb begin
        acc_put      = acc_reg;
        acc_put[{acc_cnt_reg, 3'b000} +: 8] = s1_byte;
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        m_valid_next = m_valid_reg;
        m_bytes_next = m_bytes_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && out_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_take) begin
            if (s1_done) begin
                m_valid_next = 1'b1;
                m_bytes_next = acc_put;
                m_count_next = {1'b0, acc_cnt_reg} + 3'd1;
                m_last_next  = s1_last_reg;
                acc_next     = '0;
                acc_cnt_next = 2'd0;
            end else begin
                acc_next     = acc_put;
                acc_cnt_next = acc_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            acc_cnt_reg  <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            acc_cnt_reg  <= acc_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold command, stage 1 payload and result payload
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        s1_mem_reg  <= s1_mem_next;
        s1_val_reg  <= s1_val_next;
        s1_end_reg  <= s1_end_next;
        s1_last_reg <= s1_last_next;
        m_bytes_reg <= m_bytes_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    // Literal store: write from the front, registered read per issued literal step
    always_ff @(posedge aclk) begin
        if (lit_wr.en) begin
            mem[lit_wr.addr] <= lit_wr.data;
        end
        if (issue && step_mem) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
